@@ sv/piq_pkg.sv @@
`default_nettype none

package piq_pkg;

    localparam int DEPTH     = 32;
    localparam int TAG_BYTES = 8;

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int TAG_W   = 64;
    localparam int POS_W   = 8;
    localparam int OCC_W   = 6;
    localparam int ENTRY_W = KEY_W + TAG_W;

    localparam logic [TAG_W-1:0] TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - 8 * TAG_BYTES);

    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_INSERT  = 2'd1;
    localparam logic [1:0] CMD_DEQUEUE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PLACE,
        S_RESULT
    } t_state;

    // logical place behind the head to ring address, both below DEPTH
    function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] head,
                                                input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/positional_insert_queue.sv @@
`default_nettype none

// Ordered queue of up to DEPTH entries (32-bit key, tag of TAG_BYTES bytes) kept
// as a ring in one single-port-write, single-port-read RAM with registered read
// data. Every transaction on the slave side gives exactly one transaction on
// the master side. Append, dequeue, full and empty cases and insert at the tail
// go from acceptance straight to the result state, which loads the output
// register; an insert in front of k held entries first moves them back one
// place each, then writes the new entry (shift, drain, place states). The RAM
// moves one entry back per cycle (read of one entry overlaps the write of the
// one before). A new transaction is accepted as soon as the previous result sits
// in the output register, even if that result is not yet taken; while a result
// waits for the master side the next result is held back. Commands other than
// append, insert and dequeue report ok and leave the queue unchanged.
module positional_insert_queue
    import piq_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output      logic         o_s_axis_tready,
    // entry_key[31:0], entry_tag[95:32], position[103:96]
    input  wire logic [103:0] i_s_axis_tdata,
    // command[1:0]
    input  wire logic [1:0]   i_s_axis_tuser,
    output      logic         o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // out_key[31:0], out_tag[95:32], occupancy[101:96], is_empty[102], zero[103]
    output      logic [103:0] o_m_axis_tdata,
    // item_valid[0], status[2:1]
    output      logic [2:0]   o_m_axis_tuser
);

    t_state r_state, n_state;

    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_src, n_src;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_pend_addr, n_pend_addr;
    logic [KEY_W-1:0] r_key, n_key;
    logic [TAG_W-1:0] r_tag, n_tag;
    logic             r_res_valid, n_res_valid;
    logic [1:0]       r_res_status, n_res_status;
    logic             r_out_valid, n_out_valid;
    logic [103:0]     r_out_data, n_out_data;
    logic [2:0]       r_out_user, n_out_user;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [1:0]       in_cmd;
    logic [KEY_W-1:0] in_key;
    logic [TAG_W-1:0] in_tag;
    logic [POS_W-1:0] in_pos;
    logic [15:0]      ins_idx;
    logic             in_xact;
    logic             out_free;
    logic [KEY_W-1:0] res_key;
    logic [TAG_W-1:0] res_tag;

    assign in_cmd = i_s_axis_tuser;
    assign in_key = i_s_axis_tdata[31:0];
    assign in_tag = i_s_axis_tdata[95:32] & TAG_MASK;
    assign in_pos = i_s_axis_tdata[103:96];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xact         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // 0-based target slot, front for position 0 or 1, clipped to the tail; append always takes the tail
    always_comb begin
        ins_idx = (in_pos <= 8'd1) ? 16'd0 : 16'(in_pos) - 16'd1;
        if (in_cmd == CMD_APPEND || ins_idx > 16'(r_count)) begin
            ins_idx = 16'(r_count);
        end
    end

    assign res_key = r_res_valid ? ram_rdata[KEY_W-1:0] : '0;
    assign res_tag = r_res_valid ? ram_rdata[ENTRY_W-1:KEY_W] : '0;

    piq_ram #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (ENTRY_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_src        = r_src;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_addr  = r_pend_addr;
        n_key        = r_key;
        n_tag        = r_tag;
        n_res_valid  = r_res_valid;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        ram_we       = 1'b0;
        ram_waddr    = r_pend_addr;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = phys_addr(r_head, AW'(r_src));

        unique case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    n_res_valid  = 1'b0;
                    n_res_status = ST_OK;
                    n_state      = S_RESULT;
                    case (in_cmd) inside
                        CMD_APPEND, CMD_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else if (CW'(ins_idx) == r_count) begin
                                ram_we    = 1'b1;
                                ram_waddr = phys_addr(r_head, AW'(r_count));
                                ram_wdata = {in_tag, in_key};
                                n_count   = r_count + CW'(1);
                            end else begin
                                n_src   = r_count - CW'(1);
                                n_idx   = CW'(ins_idx);
                                n_key   = in_key;
                                n_tag   = in_tag;
                                n_pend  = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        CMD_DEQUEUE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                ram_re      = 1'b1;
                                ram_raddr   = r_head;
                                n_head      = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                                n_count     = r_count - CW'(1);
                                n_res_valid = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // read entry src while the entry read last cycle goes one place back
                ram_re      = 1'b1;
                ram_we      = r_pend;
                n_pend      = 1'b1;
                n_pend_addr = phys_addr(r_head, AW'(r_src + CW'(1)));
                if (r_src == r_idx) begin
                    n_state = S_DRAIN;
                end else begin
                    n_src = r_src - CW'(1);
                end
            end
            S_DRAIN: begin
                ram_we  = 1'b1;
                n_pend  = 1'b0;
                n_state = S_PLACE;
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = phys_addr(r_head, AW'(r_idx));
                ram_wdata = {r_tag, r_key};
                n_count   = r_count + CW'(1);
                n_state   = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, (r_count == '0), OCC_W'(r_count), res_tag, res_key};
                    n_out_user  = {r_res_status, r_res_valid};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src        <= n_src;
        r_idx        <= n_idx;
        r_pend_addr  <= n_pend_addr;
        r_key        <= n_key;
        r_tag        <= n_tag;
        r_res_valid  <= n_res_valid;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_user   <= n_out_user;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_place_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |-> (r_count < CW'(DEPTH)) && (r_idx < r_count))
        else $error("insert placed without room or past the tail");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_src >= r_idx) && (r_src < r_count))
        else $error("shift source out of range");

    a_item_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user[0]) |-> (r_out_user[2:1] == ST_OK))
        else $error("dequeued entry reported with error status");
`endif

endmodule

`default_nettype wire

@@ sv/piq_ram.sv @@
`default_nettype none

module piq_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 96
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output      logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
